[rtl/ifd_pkg.sv]
// Shared constants and controller/datapath interface types for the frame deframer.
package ifd_pkg;

  localparam int unsigned FrameLen  = 11;
  localparam int unsigned FillW     = 4;
  localparam logic [7:0]  SyncReset = 8'h55;

  typedef logic [FillW-1:0] fill_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_byte;  // capture the incoming beat
    logic shift;      // drop the leading window byte
    logic push;       // append the held byte to the window
    logic clear;      // empty the window
    logic load_out;   // move the decoded frame into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;      // no bytes buffered
    logic lead_sync;  // first buffered byte equals the sync byte
    logic full;       // a whole frame is buffered
    logic sum_ok;     // checksum byte matches the sum of bytes 0..9
    logic out_busy;   // output register still holds a beat
  } sts_t;

endpackage

[rtl/ifd_datapath.sv]
// Byte window, checksum and output register of the frame deframer.
module ifd_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ifd_pkg::cmd_t     cmd_i,
  output ifd_pkg::sts_t     sts_o,
  input  logic [7:0]        rx_byte_i,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_sync_byte_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [7:0]        frame_type_o,
  output logic [15:0]       word_one_o,
  output logic [15:0]       word_two_o,
  output logic [15:0]       word_three_o,
  output logic [15:0]       word_four_o
);

  logic [7:0]     win_q [ifd_pkg::FrameLen];
  ifd_pkg::fill_t fill_q;
  logic [7:0]     hold_q;
  logic [7:0]     sync_q;
  logic           out_valid_q;
  logic [7:0]     type_q;
  logic [15:0]    w1_q, w2_q, w3_q, w4_q;

  logic [7:0]     pair_sum [5];
  logic [7:0]     sum;
  logic           at_limit;
  ifd_pkg::fill_t wr_idx;

  // Checksum over bytes 0..9 as a shallow adder tree
  always_comb begin
    for (int p = 0; p < 5; p++) begin
      pair_sum[p] = win_q[2*p] + win_q[2*p+1];
    end
    sum = (pair_sum[0] + pair_sum[1]) + (pair_sum[2] + pair_sum[3]) + pair_sum[4];
  end

  assign at_limit = (fill_q >= ifd_pkg::fill_t'(ifd_pkg::FrameLen));
  assign wr_idx   = at_limit ? '0 : fill_q;

  assign sts_o.empty     = (fill_q == '0);
  assign sts_o.lead_sync = (win_q[0] == sync_q);
  assign sts_o.full      = at_limit;
  assign sts_o.sum_ok    = (sum == win_q[ifd_pkg::FrameLen-1]);
  assign sts_o.out_busy  = out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte) begin
      hold_q <= rx_byte_i;
    end
    for (int i = 0; i < ifd_pkg::FrameLen; i++) begin
      if (cmd_i.shift) begin
        if (i < ifd_pkg::FrameLen - 1) begin
          win_q[i] <= win_q[i+1];
        end
      end else if (cmd_i.push && (wr_idx == ifd_pkg::fill_t'(i))) begin
        win_q[i] <= hold_q;
      end
    end
    if (cmd_i.load_out) begin
      type_q <= win_q[1];
      w1_q   <= {win_q[3], win_q[2]};
      w2_q   <= {win_q[5], win_q[4]};
      w3_q   <= {win_q[7], win_q[6]};
      w4_q   <= {win_q[9], win_q[8]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      sync_q      <= ifd_pkg::SyncReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sync_q <= cfg_sync_byte_i;
      end
      if (cmd_i.clear) begin
        fill_q <= '0;
      end else if (cmd_i.shift) begin
        fill_q <= fill_q - 1'b1;
      end else if (cmd_i.push) begin
        fill_q <= wr_idx + 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_type_o = type_q;
  assign word_one_o   = w1_q;
  assign word_two_o   = w2_q;
  assign word_three_o = w3_q;
  assign word_four_o  = w4_q;

endmodule

[rtl/ifd_ctrl.sv]
// Sequencing state machine of the frame deframer.
module ifd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ifd_pkg::sts_t sts_i,
  output ifd_pkg::cmd_t cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StPre   = 2'd1;
  localparam logic [1:0] StPost  = 2'd2;
  localparam logic [1:0] StCheck = 2'd3;

  logic [1:0] state_q, state_d;
  logic       strip;

  assign strip = !sts_i.empty && !sts_i.lead_sync;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_byte = 1'b1;
          state_d         = StPre;
        end
      end
      StPre: begin
        // drop stale lead bytes, then append the held byte
        if (strip) begin
          cmd_o.shift = 1'b1;
        end else begin
          cmd_o.push = 1'b1;
          state_d    = StPost;
        end
      end
      StPost: begin
        if (strip) begin
          cmd_o.shift = 1'b1;
        end else begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (!sts_i.full) begin
          state_d = StIdle;
        end else if (sts_i.sum_ok) begin
          // hold until the output register is free
          if (!sts_i.out_busy) begin
            cmd_o.load_out = 1'b1;
            cmd_o.clear    = 1'b1;
            state_d        = StIdle;
          end
        end else begin
          cmd_o.shift = 1'b1;
          state_d     = StPost;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

[rtl/imu_frame_deframer.sv]
// Top level of the sync-byte frame deframer with additive checksum.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------------
//   in      | sink      | in_valid_i / in_stall_o | rx_byte_i
//   out     | source    | out_valid_o / out_stall_i | frame_type_o, word_one_o..four_o
//   cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_sync_byte_i
//
// One input beat passes the idle, pre, post and check steps, plus a step per buffered
// byte dropped while searching for the sync byte and a further shift and post pass per
// checksum failure; the window drops one buffered byte per cycle.
// Reset empties the window and loads sync byte 0x55; no clearing pass.
// The output register lets the next beat be taken while a frame waits; a
// finished frame waits in the check step while the previous one is still held.
module imu_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_type_o,
  output logic [15:0] word_one_o,
  output logic [15:0] word_two_o,
  output logic [15:0] word_three_o,
  output logic [15:0] word_four_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_sync_byte_i
);

  ifd_pkg::cmd_t cmd;
  ifd_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  ifd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ifd_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .rx_byte_i       (rx_byte_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_sync_byte_i (cfg_sync_byte_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .frame_type_o    (frame_type_o),
    .word_one_o      (word_one_o),
    .word_two_o      (word_two_o),
    .word_three_o    (word_three_o),
    .word_four_o     (word_four_o)
  );

endmodule

[rtl/ifd_checker.sv]
// Port-level checks for the frame deframer, bound to the top level.
module ifd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  frame_type_o,
  input logic [15:0] word_one_o,
  input logic [15:0] word_two_o,
  input logic [15:0] word_three_o,
  input logic [15:0] word_four_o
);

  // a taken byte keeps the input stalled while it is worked on
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an accepted beat");

  // a frame is only produced by work on a byte
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an input beat in progress");

  // a taken result is not followed at once by another
  a_no_back_to_back_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=> !out_valid_o)
    else $error("output valid right after a taken beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(frame_type_o)
      && $stable(word_one_o) && $stable(word_two_o)
      && $stable(word_three_o) && $stable(word_four_o)))
    else $error("stalled output beat changed");

endmodule

bind imu_frame_deframer ifd_checker u_ifd_checker (.*);

[tb/tb_imu_frame_deframer.sv]
// Self-checking testbench for the sync-byte frame deframer with additive checksum.
`timescale 1ns / 1ps

module tb_imu_frame_deframer;

  localparam int unsigned DrainCycles = 64;     // margin for the longest beat plus output waits
  localparam int unsigned DrainBound  = 20000;

  typedef struct packed {
    logic [7:0]  ftype;
    logic [15:0] w1;
    logic [15:0] w2;
    logic [15:0] w3;
    logic [15:0] w4;
  } frame_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i       = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [7:0]  frame_type_o;
  logic [15:0] word_one_o;
  logic [15:0] word_two_o;
  logic [15:0] word_three_o;
  logic [15:0] word_four_o;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_sync_byte_i = 8'h00;

  // Deframer model state
  logic [7:0]  win [ifd_pkg::FrameLen];
  int unsigned win_fill = 0;
  logic [7:0]  sync_cfg = ifd_pkg::SyncReset;
  frame_t      frames_due[$];

  int          err_cnt    = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_span = 0;

  imu_frame_deframer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_type_o   (frame_type_o),
    .word_one_o     (word_one_o),
    .word_two_o     (word_two_o),
    .word_three_o   (word_three_o),
    .word_four_o    (word_four_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_sync_byte_i(cfg_sync_byte_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void drop_lead(int unsigned n);
    if (n >= win_fill) begin
      win_fill = 0;
    end else begin
      for (int unsigned i = 0; i < win_fill - n; i++) win[i] = win[i + n];
      win_fill = win_fill - n;
    end
  endfunction

  function automatic void seek_sync();
    int unsigned i;
    i = 0;
    while (i < win_fill && win[i] != sync_cfg) i++;
    drop_lead(i);
  endfunction

  // Append one byte and queue the frame it completes, if any
  function automatic void deframe_byte(logic [7:0] b);
    logic [7:0] sum;
    frame_t     f;
    seek_sync();
    if (win_fill >= ifd_pkg::FrameLen) win_fill = 0;
    win[win_fill] = b;
    win_fill++;
    while (1'b1) begin
      seek_sync();
      if (win_fill < ifd_pkg::FrameLen) return;
      sum = 8'h00;
      for (int unsigned k = 0; k < ifd_pkg::FrameLen - 1; k++) sum = sum + win[k];
      if (sum == win[ifd_pkg::FrameLen - 1]) begin
        f.ftype = win[1];
        f.w1    = {win[3], win[2]};
        f.w2    = {win[5], win[4]};
        f.w3    = {win[7], win[6]};
        f.w4    = {win[9], win[8]};
        frames_due.push_back(f);
        win_fill = 0;
        return;
      end
      // bad checksum: drop the leading sync and rescan
      drop_lead(1);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    deframe_byte(b);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? 120 : $urandom_range(1, 16);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  // Send a frame under the current sync byte; truncate to n_bytes, optionally corrupt the sum
  task automatic send_frame(input logic [7:0] ftype, input logic [63:0] words,
                            input bit corrupt, input int unsigned n_bytes);
    logic [7:0]  sum;
    logic [7:0]  b;
    sum = 8'h00;
    for (int unsigned k = 0; k < n_bytes && k < ifd_pkg::FrameLen; k++) begin
      if (k == 0) b = sync_cfg;
      else if (k == 1) b = ftype;
      else if (k < ifd_pkg::FrameLen - 1) b = words[8*(k-2) +: 8];
      else b = corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum;
      sum = sum + b;
      send_byte(b);
    end
  endtask

  // Hold the sender until every frame due has come or the drain bound runs out, then let the block settle
  task automatic wait_frames_done();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    for (int unsigned i = 0; i < DrainBound && frames_due.size() != 0; i++) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_sync(input logic [7:0] v);
    wait_frames_done();
    @(negedge clk_i);
    cfg_valid_i     <= 1'b1;
    cfg_sync_byte_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sync_cfg = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_frame_extremes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'h00, 64'h0, 1'b0, ifd_pkg::FrameLen);
    send_frame(8'hFF, {64{1'b1}}, 1'b0, ifd_pkg::FrameLen);
  endtask

  task automatic test_checksum_rescan();
    // sync inside the payload of a bad frame forces a rescan from there
    send_frame(8'h12, {16'h3456, 8'h00, sync_cfg, 32'h789A_BCDE}, 1'b1, ifd_pkg::FrameLen);
    send_frame(8'hA5, 64'h0123_4567_89AB_CDEF, 1'b0, ifd_pkg::FrameLen);
  endtask

  task automatic test_sync_change();
    send_frame(8'h3C, 64'h0, 1'b0, 5);
    set_sync(8'hFF);
    send_frame(8'h01, 64'hFFFF_0000_FFFF_0000, 1'b0, ifd_pkg::FrameLen);
    set_sync(8'h00);
    send_frame(8'h00, 64'h0, 1'b0, ifd_pkg::FrameLen);
    send_frame(8'h80, 64'h8000_0001_8000_0001, 1'b0, ifd_pkg::FrameLen);
  endtask

  task automatic test_random_stream(input int unsigned n_bytes);
    int unsigned sent;
    int unsigned kind;
    logic [63:0] words;
    sent = 0;
    while (sent < n_bytes) begin
      kind  = $urandom_range(0, 9);
      words = {$urandom(), $urandom()};
      if (kind == 9) begin
        for (int j = 0; j < 8; j++) if ($urandom_range(0, 2) == 0) words[8*j +: 8] = sync_cfg;
      end
      case (kind)
        6: begin
          send_frame(8'($urandom()), words, 1'b1, ifd_pkg::FrameLen);
          sent += ifd_pkg::FrameLen;
        end
        7: begin
          repeat ($urandom_range(1, 5)) send_byte(8'($urandom()));
        end
        8: begin
          send_frame(8'($urandom()), words, 1'b0, $urandom_range(1, ifd_pkg::FrameLen - 1));
          sent += 5;
        end
        default: begin
          send_frame(8'($urandom()), words, 1'b0, ifd_pkg::FrameLen);
          sent += ifd_pkg::FrameLen;
        end
      endcase
      if (sent >= n_bytes / 2 && sent < n_bytes / 2 + ifd_pkg::FrameLen) wait_frames_done();
    end
  endtask

  // Receiver stall pattern: free-flowing, light and heavy spans
  always @(negedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_span = $urandom_range(40, 300);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s expected %0h actual %0h", name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    frame_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frames_due.size() == 0) begin
        $error("frame with no expectation: type %0h", frame_type_o);
        err_cnt++;
      end else begin
        want = frames_due.pop_front();
        check_field("frame_type", {8'h00, want.ftype}, {8'h00, frame_type_o});
        check_field("word_one", want.w1, word_one_o);
        check_field("word_two", want.w2, word_two_o);
        check_field("word_three", want.w3, word_three_o);
        check_field("word_four", want.w4, word_four_o);
      end
    end
  end

  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_frame_extremes();
    test_checksum_rescan();
    test_sync_change();
    test_random_stream(250);
    set_sync(8'($urandom()));
    test_random_stream(250);
    set_sync(ifd_pkg::SyncReset);
    test_random_stream(250);
    set_sync(8'hFF);
    test_random_stream(250);
    wait_frames_done();
    if (frames_due.size() != 0) begin
      $error("%0d frames never came out", frames_due.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/ifd_pkg.sv
rtl/ifd_datapath.sv
rtl/ifd_ctrl.sv
rtl/imu_frame_deframer.sv
rtl/ifd_checker.sv
tb/tb_imu_frame_deframer.sv
